// ===== src/undo_redo_char_buffer_unit_assert.svh =====
// Assertion macros for the undo and redo character buffer.
`ifndef UNDO_REDO_CHAR_BUFFER_UNIT_ASSERT_SVH
`define UNDO_REDO_CHAR_BUFFER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/urcb_pkg.sv =====
// Types and constants shared by the undo and redo character buffer.
`timescale 1ns / 1ps

package urcb_pkg;

  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 9;
  localparam int ENTRY_W  = CHAR_W + 1;
  localparam int KIND_BIT = CHAR_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_TYPE   = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_UNDO   = 2'd2,
    REQ_REDO   = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NO_UNDO = 3'd2,
    ST_NO_REDO = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

endpackage

// ===== src/urcb_if.sv =====
// Request and result channel interfaces of the undo and redo character buffer.
`timescale 1ns / 1ps

interface urcb_req_if;
  logic                          valid;
  logic                          ready;
  logic [urcb_pkg::REQ_W-1:0]    req_type;
  logic [urcb_pkg::CHAR_W-1:0]   char_in;

  modport source (output valid, output req_type, output char_in, input ready);
  modport sink (input valid, input req_type, input char_in, output ready);
endinterface

interface urcb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [urcb_pkg::STATUS_W-1:0] status;
  logic [urcb_pkg::LEN_W-1:0]    text_len;
  logic [urcb_pkg::CHAR_W-1:0]   top_char;
  logic [urcb_pkg::CHAR_W-1:0]   touched_char;

  modport source (output valid, output status, output text_len, output top_char,
                  output touched_char, input ready);
  modport sink (input valid, input status, input text_len, input top_char,
                input touched_char, output ready);
endinterface

// ===== src/undo_redo_char_buffer_unit.sv =====
// Top level of the undo and redo character buffer with its three stack memories.
`timescale 1ns / 1ps
`include "undo_redo_char_buffer_unit_assert.svh"

// The cycle in which a request is accepted launches reads of the buffer top,
// the entry below it and both history tops from the synchronous memories; the
// execute state then decides the outcome, writes the memories back and loads
// the result register, and it stays there while a previous result has not
// been taken. A new request is taken once the execute state has finished.
// The stores are not cleared after reset, so the block is ready in the first
// cycle after reset.
module undo_redo_char_buffer_unit #(
  parameter int TEXT_DEPTH    = 256,
  parameter int HISTORY_DEPTH = 256
) (
  input logic       clk,
  input logic       rst,
  urcb_req_if.sink  req,
  urcb_rsp_if.source rsp
);

  import urcb_pkg::*;

  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int TCW = $clog2(TEXT_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [CHAR_W-1:0]  text_mem [TEXT_DEPTH];
  logic [ENTRY_W-1:0] undo_mem [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] redo_mem [HISTORY_DEPTH];

  logic [TCW-1:0] t_cnt, t_new, t_m1, t_m2;
  logic [HCW-1:0] u_cnt, u_new, u_m1;
  logic [HCW-1:0] r_cnt, r_new, r_m1;

  req_kind_t         req_q;
  logic [CHAR_W-1:0] char_q;

  logic [CHAR_W-1:0]  t_rd1, t_rd2;
  logic [ENTRY_W-1:0] u_rd, r_rd;

  logic               t_we, u_we, r_we;
  logic [CHAR_W-1:0]  t_wdata;
  logic [ENTRY_W-1:0] u_wdata, r_wdata;

  logic t_full, t_empty, u_full, r_full;
  logic rd_en, exec_fire;

  status_t           st;
  logic [CHAR_W-1:0] touched, new_top;
  logic [ENTRY_W-1:0] ent;
  logic              adds;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [LEN_W-1:0]    out_len;
  logic [CHAR_W-1:0]   out_top;
  logic [CHAR_W-1:0]   out_touched;

  assign req.ready = (state == S_IDLE);
  assign rd_en     = req.valid && req.ready;
  assign exec_fire = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign t_m1 = t_cnt - TCW'(1);
  assign t_m2 = t_cnt - TCW'(2);
  assign u_m1 = u_cnt - HCW'(1);
  assign r_m1 = r_cnt - HCW'(1);

  assign t_full  = (t_cnt >= TCW'(TEXT_DEPTH));
  assign t_empty = (t_cnt == '0);
  assign u_full  = (u_cnt >= HCW'(HISTORY_DEPTH));
  assign r_full  = (r_cnt >= HCW'(HISTORY_DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (rd_en) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q <= REQ_TYPE;
    end else if (rd_en) begin
      req_q  <= req_kind_t'(req.req_type);
      char_q <= req.char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      t_rd1 <= text_mem[t_m1[TAW-1:0]];
      t_rd2 <= text_mem[t_m2[TAW-1:0]];
      u_rd  <= undo_mem[u_m1[HAW-1:0]];
      r_rd  <= redo_mem[r_m1[HAW-1:0]];
    end
    if (exec_fire && t_we) text_mem[t_cnt[TAW-1:0]] <= t_wdata;
    if (exec_fire && u_we) undo_mem[u_cnt[HAW-1:0]] <= u_wdata;
    if (exec_fire && r_we) redo_mem[r_cnt[HAW-1:0]] <= r_wdata;
  end

  always_comb begin
    st      = ST_OK;
    touched = '0;
    t_new   = t_cnt;
    u_new   = u_cnt;
    r_new   = r_cnt;
    t_we    = 1'b0;
    u_we    = 1'b0;
    r_we    = 1'b0;
    t_wdata = char_q;
    u_wdata = {1'b0, char_q};
    r_wdata = r_rd;
    ent     = u_rd;
    adds    = 1'b0;
    unique case (req_q)
      REQ_TYPE: begin
        if (t_full || u_full) begin
          st = ST_FULL;
        end else begin
          t_we    = 1'b1;
          u_we    = 1'b1;
          t_new   = t_cnt + TCW'(1);
          u_new   = u_cnt + HCW'(1);
          r_new   = '0;
          touched = char_q;
        end
      end
      REQ_DELETE: begin
        if (t_empty) begin
          st = ST_EMPTY;
        end else if (u_full) begin
          st = ST_FULL;
        end else begin
          t_new   = t_m1;
          touched = t_rd1;
          u_we    = 1'b1;
          u_wdata = {1'b1, t_rd1};
          u_new   = u_cnt + HCW'(1);
          r_new   = '0;
        end
      end
      REQ_UNDO: begin
        ent  = u_rd;
        adds = ent[KIND_BIT];
        if (u_cnt == '0) begin
          st = ST_NO_UNDO;
        end else if (r_full) begin
          st = ST_FULL;
        end else if (adds) begin
          if (t_full) begin
            st = ST_FULL;
          end else begin
            t_we    = 1'b1;
            t_wdata = ent[CHAR_W-1:0];
            t_new   = t_cnt + TCW'(1);
            touched = ent[CHAR_W-1:0];
          end
        end else if (t_empty) begin
          st = ST_EMPTY;
        end else begin
          t_new   = t_m1;
          touched = t_rd1;
        end
        if (st == ST_OK) begin
          u_new   = u_m1;
          r_we    = 1'b1;
          r_wdata = ent;
          r_new   = r_cnt + HCW'(1);
        end
      end
      REQ_REDO: begin
        ent  = r_rd;
        adds = !ent[KIND_BIT];
        if (r_cnt == '0) begin
          st = ST_NO_REDO;
        end else if (u_full) begin
          st = ST_FULL;
        end else if (adds) begin
          if (t_full) begin
            st = ST_FULL;
          end else begin
            t_we    = 1'b1;
            t_wdata = ent[CHAR_W-1:0];
            t_new   = t_cnt + TCW'(1);
            touched = ent[CHAR_W-1:0];
          end
        end else if (t_empty) begin
          st = ST_EMPTY;
        end else begin
          t_new   = t_m1;
          touched = t_rd1;
        end
        if (st == ST_OK) begin
          r_new   = r_m1;
          u_we    = 1'b1;
          u_wdata = ent;
          u_new   = u_cnt + HCW'(1);
        end
      end
    endcase
  end

  always_comb begin
    if (t_we) begin
      new_top = t_wdata;
    end else if (t_new != t_cnt) begin
      new_top = (t_new == '0) ? '0 : t_rd2;
    end else begin
      new_top = t_empty ? '0 : t_rd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_cnt <= '0;
      u_cnt <= '0;
      r_cnt <= '0;
    end else if (exec_fire) begin
      t_cnt <= t_new;
      u_cnt <= u_new;
      r_cnt <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status  <= st;
      out_len     <= LEN_W'(t_new);
      out_top     <= new_top;
      out_touched <= touched;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.text_len     = out_len;
  assign rsp.top_char     = out_top;
  assign rsp.touched_char = out_touched;

  `URCB_ASSERT_SAME(a_count_bound, 1'b1,
    t_cnt <= TCW'(TEXT_DEPTH) && u_cnt <= HCW'(HISTORY_DEPTH) && r_cnt <= HCW'(HISTORY_DEPTH),
    "A stack count exceeds its depth.")
  `URCB_ASSERT_NEXT(a_error_keeps_state, exec_fire && st != ST_OK,
    $stable(t_cnt) && $stable(u_cnt) && $stable(r_cnt),
    "A rejected request changed a stack count.")
  `URCB_ASSERT_NEXT(a_edit_clears_redo,
    exec_fire && st == ST_OK && (req_q == REQ_TYPE || req_q == REQ_DELETE),
    r_cnt == '0 && u_cnt == $past(u_cnt) + HCW'(1),
    "An edit did not push the undo history and clear the redo history.")

endmodule
